// ----- sv/remote_control_frame_parser_core_macros.svh -----
// Assertion macros used by the frame parser controller.
`ifndef REMOTE_CONTROL_FRAME_PARSER_CORE_MACROS_SVH
`define REMOTE_CONTROL_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rcfp_pkg.sv -----
// Types and constants shared by the frame parser modules.
package rcfp_pkg;

  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_F = 8'h66;
  localparam logic [7:0] CHAR_LOW_G = 8'h67;

  localparam logic [2:0] MODE_RESET = 3'd1;
  localparam logic [2:0] MODE_ZERO  = 3'd0;
  localparam logic [2:0] MODE_ATT   = 3'd2;
  localparam logic [2:0] MODE_REMAP = 3'd4;

  localparam logic [1:0] CH_LEFT  = 2'd0;
  localparam logic [1:0] CH_RIGHT = 2'd1;
  localparam logic [1:0] CH_ATT   = 2'd2;

  localparam int unsigned MAX_RESULTS = 20;
  localparam int unsigned RES_CNT_W   = 5;
  localparam int unsigned POS_W       = 5;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_SEND = 3'b100
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic eval;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } dp_sts_t;

  typedef struct packed {
    logic             kind;
    logic [1:0]       channel;
    logic [7:0]       frame_byte;
    logic [POS_W-1:0] position;
    logic             frame_empty;
    logic             frame_overflow;
    logic [2:0]       mode;
    logic             last;
  } result_t;

endpackage

// ----- sv/rcfp_intf.sv -----
// Valid/ready channel interfaces for received bytes and parser results.
interface rcfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfp_result_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [1:0]                      channel;
  logic [7:0]                      frame_byte;
  logic [rcfp_pkg::POS_W-1:0]      position;
  logic                            frame_empty;
  logic                            frame_overflow;
  logic [2:0]                      mode;
  logic                            last;

  modport source (output valid, output kind, output channel, output frame_byte,
                  output position, output frame_empty, output frame_overflow,
                  output mode, output last, input ready);
  modport sink (input valid, input kind, input channel, input frame_byte,
                input position, input frame_empty, input frame_overflow,
                input mode, input last, output ready);
endinterface

// ----- sv/rcfp_ctrl.sv -----
// Controller state machine: accept a byte, evaluate it, send its results.
`include "remote_control_frame_parser_core_macros.svh"

module rcfp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rcfp_pkg::dp_sts_t sts_i,
  output rcfp_pkg::dp_cmd_t cmd_o
);

  rcfp_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcfp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rcfp_pkg::ST_EVAL;
      end
      rcfp_pkg::ST_EVAL: begin
        state_d = rcfp_pkg::ST_SEND;
      end
      rcfp_pkg::ST_SEND: begin
        if (sts_i.out_free && sts_i.last) state_d = rcfp_pkg::ST_IDLE;
      end
      default: begin
        state_d = rcfp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcfp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o   = (state_q == rcfp_pkg::ST_IDLE);
  assign cmd_o.accept = in_ready_o && in_valid_i;
  assign cmd_o.eval   = (state_q == rcfp_pkg::ST_EVAL);
  assign cmd_o.load   = (state_q == rcfp_pkg::ST_SEND) && sts_i.out_free;

  `RCFP_ASSERT_NEXT(a_accept_eval, cmd_o.accept, state_q == rcfp_pkg::ST_EVAL, "accept without eval")
  `RCFP_ASSERT_NEXT(a_eval_send, state_q == rcfp_pkg::ST_EVAL, state_q == rcfp_pkg::ST_SEND, "eval not followed by send")
  `RCFP_ASSERT_NEXT(a_last_idle, cmd_o.load && sts_i.last, state_q == rcfp_pkg::ST_IDLE, "last result did not end send")
  `RCFP_ASSERT_NEXT(a_stall_hold, (state_q == rcfp_pkg::ST_SEND) && !sts_i.out_free, state_q == rcfp_pkg::ST_SEND, "send left while stalled")

endmodule

// ----- sv/rcfp_datapath.sv -----
// Datapath: mode and frame state, frame stores, result cursor, output register.
module rcfp_datapath #(
  parameter int unsigned STICK_FRAME_BYTES    = 10,
  parameter int unsigned ATTITUDE_FRAME_BYTES = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcfp_pkg::dp_cmd_t cmd_i,
  output rcfp_pkg::dp_sts_t sts_o,
  input  logic [7:0]        rx_byte_i,
  output rcfp_pkg::result_t res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);

  localparam int unsigned SIW = $clog2(STICK_FRAME_BYTES);
  localparam int unsigned AIW = $clog2(ATTITUDE_FRAME_BYTES);
  localparam int unsigned SCW = $clog2(STICK_FRAME_BYTES + 1);
  localparam int unsigned ACW = $clog2(ATTITUDE_FRAME_BYTES + 1);
  localparam int unsigned LW  = (SCW > ACW) ? SCW : ACW;
  localparam int unsigned PW  = (LW > rcfp_pkg::POS_W) ? LW : rcfp_pkg::POS_W;
  localparam int unsigned RW  = rcfp_pkg::RES_CNT_W;

  logic [7:0]     byte_q;
  logic [2:0]     mode_q, mode_d;
  logic           seen_q, seen_d;
  logic [2:0]     act_q, act_d;
  logic [1:0]     first_q, first_d;
  logic [2:0]     ovf_q, ovf_d;
  logic [SCW-1:0] lcnt_q, lcnt_d;
  logic [SCW-1:0] rcnt_q, rcnt_d;
  logic [ACW-1:0] acnt_q, acnt_d;

  logic [7:0] left_mem [STICK_FRAME_BYTES];
  logic [7:0] right_mem [STICK_FRAME_BYTES];
  logic [7:0] att_mem [ATTITUDE_FRAME_BYTES];
  logic [7:0] rd_l_q, rd_r_q, rd_a_q;

  logic [2:0]         pend_q, pend_d;
  logic [1:0]         empty_q, empty_d;
  logic [2:0][PW-1:0] len_q, len_d;
  logic [2:0]         povf_q, povf_d;
  logic               status_q, status_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [RW-1:0]      n_q;

  logic           wr_l, wr_r, wr_a;
  logic [SIW-1:0] wr_l_idx, wr_r_idx;
  logic [AIW-1:0] wr_a_idx;

  logic                  is_cmd, is_sel;
  logic [2:0]            mode_sel;
  logic                  l_act, r_act, a_act, a_ovf;
  logic [ACW-1:0]        a_cnt;

  logic [1:0]        cur;
  logic [2:0]        cur_mask;
  logic [PW-1:0]     cur_len;
  logic              cur_empty;
  logic              cur_ovf;
  logic [7:0]        cur_byte;
  logic [PW-1:0]     pos_inc;
  logic              seg_end;
  logic [2:0]        pend_after;
  logic              last;
  rcfp_pkg::result_t res_d, res_q;
  logic              res_valid_q;

  always_comb begin
    is_cmd = (byte_q >= rcfp_pkg::CHAR_LOW_A) && (byte_q <= rcfp_pkg::CHAR_LOW_F);
    is_sel = (byte_q >= rcfp_pkg::CHAR_LOW_A) && (byte_q <= rcfp_pkg::CHAR_LOW_G);
    mode_sel = is_sel ? 3'(byte_q - rcfp_pkg::CHAR_LOW_A + 8'd1) : mode_q;
    mode_d = mode_sel;
    seen_d = seen_q;
    if (!seen_q && (mode_sel == rcfp_pkg::MODE_REMAP)) begin
      mode_d = rcfp_pkg::MODE_ZERO;
      seen_d = 1'b1;
    end

    act_d    = act_q;
    first_d  = first_q;
    ovf_d    = ovf_q;
    lcnt_d   = lcnt_q;
    rcnt_d   = rcnt_q;
    acnt_d   = acnt_q;
    wr_l     = 1'b0;
    wr_r     = 1'b0;
    wr_a     = 1'b0;
    wr_l_idx = lcnt_q[SIW-1:0];
    wr_r_idx = rcnt_q[SIW-1:0];
    pend_d   = '0;
    empty_d  = '0;
    len_d    = '0;
    povf_d   = '0;
    l_act    = act_q[0] || (byte_q == rcfp_pkg::CHAR_L);
    r_act    = act_q[1] || (byte_q == rcfp_pkg::CHAR_R);
    a_act    = act_q[2] || (byte_q == rcfp_pkg::CHAR_A);
    a_cnt    = (byte_q == rcfp_pkg::CHAR_A) ? '0 : acnt_q;
    a_ovf    = (byte_q == rcfp_pkg::CHAR_A) ? 1'b0 : ovf_q[2];
    wr_a_idx = a_cnt[AIW-1:0];

    if (mode_d != rcfp_pkg::MODE_ATT) begin
      act_d[0] = l_act;
      if (l_act && !is_cmd) begin
        if (lcnt_q < SCW'(STICK_FRAME_BYTES)) begin
          wr_l   = 1'b1;
          lcnt_d = lcnt_q + 1'b1;
        end else begin
          ovf_d[0] = 1'b1;
        end
        if (byte_q == rcfp_pkg::CHAR_STAR) begin
          pend_d[0] = 1'b1;
          povf_d[0] = ovf_d[0];
          len_d[0]  = PW'(lcnt_d);
          if (!first_q[0]) begin
            empty_d[0] = 1'b1;
            first_d[0] = 1'b1;
          end
          act_d[0] = 1'b0;
          ovf_d[0] = 1'b0;
          lcnt_d   = '0;
        end
      end
      act_d[1] = r_act;
      if (r_act && !is_cmd) begin
        if (rcnt_q < SCW'(STICK_FRAME_BYTES)) begin
          wr_r   = 1'b1;
          rcnt_d = rcnt_q + 1'b1;
        end else begin
          ovf_d[1] = 1'b1;
        end
        if (byte_q == rcfp_pkg::CHAR_STAR) begin
          pend_d[1] = 1'b1;
          povf_d[1] = ovf_d[1];
          len_d[1]  = PW'(rcnt_d);
          if (!first_q[1]) begin
            empty_d[1] = 1'b1;
            first_d[1] = 1'b1;
          end
          act_d[1] = 1'b0;
          ovf_d[1] = 1'b0;
          rcnt_d   = '0;
        end
      end
    end else begin
      act_d[2] = a_act;
      acnt_d   = a_cnt;
      ovf_d[2] = a_ovf;
      if (a_act && !is_cmd) begin
        if (a_cnt < ACW'(ATTITUDE_FRAME_BYTES)) begin
          wr_a   = 1'b1;
          acnt_d = a_cnt + 1'b1;
        end else begin
          ovf_d[2] = 1'b1;
        end
        if (byte_q == rcfp_pkg::CHAR_STAR) begin
          pend_d[2] = 1'b1;
          povf_d[2] = ovf_d[2];
          len_d[2]  = PW'(acnt_d);
          act_d[2]  = 1'b0;
          ovf_d[2]  = 1'b0;
          acnt_d    = '0;
        end
      end
    end
    status_d = (pend_d == 3'b000);
  end

  always_comb begin
    if (pend_q[0]) begin
      cur = rcfp_pkg::CH_LEFT;
    end else if (pend_q[1]) begin
      cur = rcfp_pkg::CH_RIGHT;
    end else begin
      cur = rcfp_pkg::CH_ATT;
    end
    cur_mask  = 3'b001 << cur;
    cur_len   = len_q[cur];
    cur_ovf   = povf_q[cur];
    cur_empty = (cur != rcfp_pkg::CH_ATT) && empty_q[cur[0]];
    case (cur)
      rcfp_pkg::CH_LEFT:  cur_byte = rd_l_q;
      rcfp_pkg::CH_RIGHT: cur_byte = rd_r_q;
      default:            cur_byte = rd_a_q;
    endcase
    pos_inc    = pos_q + 1'b1;
    seg_end    = cur_empty || (pos_inc >= cur_len);
    pend_after = seg_end ? (pend_q & ~cur_mask) : pend_q;
    last       = status_q || (pend_after == 3'b000) || (n_q == RW'(rcfp_pkg::MAX_RESULTS - 1));

    res_d = '0;
    res_d.mode = mode_q;
    res_d.last = last;
    if (!status_q) begin
      res_d.kind           = 1'b1;
      res_d.channel        = cur;
      res_d.frame_empty    = cur_empty;
      res_d.frame_overflow = cur_ovf;
      if (!cur_empty) begin
        res_d.frame_byte = cur_byte;
        res_d.position   = pos_q[rcfp_pkg::POS_W-1:0];
      end
    end

    if (cmd_i.eval) begin
      pos_d = '0;
    end else if (cmd_i.load) begin
      pos_d = seg_end ? '0 : pos_inc;
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rcfp_pkg::MODE_RESET;
      seen_q   <= 1'b0;
      act_q    <= '0;
      first_q  <= '0;
      ovf_q    <= '0;
      lcnt_q   <= '0;
      rcnt_q   <= '0;
      acnt_q   <= '0;
      pend_q   <= '0;
      status_q <= 1'b0;
      pos_q    <= '0;
      n_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        mode_q   <= mode_d;
        seen_q   <= seen_d;
        act_q    <= act_d;
        first_q  <= first_d;
        ovf_q    <= ovf_d;
        lcnt_q   <= lcnt_d;
        rcnt_q   <= rcnt_d;
        acnt_q   <= acnt_d;
        pend_q   <= pend_d;
        status_q <= status_d;
        n_q      <= '0;
      end else if (cmd_i.load) begin
        pend_q <= pend_after;
        n_q    <= n_q + 1'b1;
      end
      pos_q <= pos_d;
      if (cmd_i.load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) byte_q <= rx_byte_i;
    if (cmd_i.eval) begin
      empty_q <= empty_d;
      len_q   <= len_d;
      povf_q  <= povf_d;
    end
    if (cmd_i.load) res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && wr_l) left_mem[wr_l_idx] <= byte_q;
    if (pos_d < PW'(STICK_FRAME_BYTES)) rd_l_q <= left_mem[pos_d[SIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && wr_r) right_mem[wr_r_idx] <= byte_q;
    if (pos_d < PW'(STICK_FRAME_BYTES)) rd_r_q <= right_mem[pos_d[SIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && wr_a) att_mem[wr_a_idx] <= byte_q;
    if (pos_d < PW'(ATTITUDE_FRAME_BYTES)) rd_a_q <= att_mem[pos_d[AIW-1:0]];
  end

  assign sts_o.out_free = !res_valid_q || res_ready_i;
  assign sts_o.last     = last;
  assign res_o          = res_q;
  assign res_valid_o    = res_valid_q;

endmodule

// ----- sv/remote_control_frame_parser_core.sv -----
// Top level of the remote control frame parser.
// Usage:
//   in_i carries one received byte per item (rx_byte). out_o carries results:
//   a status-only item when no frame completes, otherwise the bytes of each
//   completed frame (left stick, then right stick, or the attitude frame),
//   or one empty item for the first frame seen on a stick channel. At most
//   20 results per byte; last marks the final one, mode comes with each.
// Timing:
//   A byte is taken while idle, evaluated in the next cycle, and its first
//   result is registered in the send state once the output register is free.
//   Results then leave one per cycle while out_o.ready is high, read from the
//   frame stores through a registered read port. Each byte gives 1 to 20
//   results; in_i.ready is high only while no byte is being worked on.
// Reset:
//   rst_ni clears mode to 1, all open frames, counts and flags; the stores
//   keep no reset value and only bytes below their fill counts are sent.
// Stall:
//   The output register holds its item while out_o.ready is low and the
//   sequencer waits; the next byte is taken while the last result waits.
module remote_control_frame_parser_core #(
  parameter int unsigned STICK_FRAME_BYTES    = 10,
  parameter int unsigned ATTITUDE_FRAME_BYTES = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rcfp_byte_if.sink     in_i,
  rcfp_result_if.source out_o
);

  rcfp_pkg::dp_cmd_t cmd;
  rcfp_pkg::dp_sts_t sts;
  rcfp_pkg::result_t res;
  logic              in_ready;

  rcfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rcfp_datapath #(
    .STICK_FRAME_BYTES    (STICK_FRAME_BYTES),
    .ATTITUDE_FRAME_BYTES (ATTITUDE_FRAME_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rx_byte_i   (in_i.rx_byte),
    .res_o       (res),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready)
  );

  assign in_i.ready           = in_ready;
  assign out_o.kind           = res.kind;
  assign out_o.channel        = res.channel;
  assign out_o.frame_byte     = res.frame_byte;
  assign out_o.position       = res.position;
  assign out_o.frame_empty    = res.frame_empty;
  assign out_o.frame_overflow = res.frame_overflow;
  assign out_o.mode           = res.mode;
  assign out_o.last           = res.last;

endmodule
